// ===== rtl/bls_pkg.sv =====
package bls_pkg;

	localparam int MAX_SRC_WIDTH  = 256;
	localparam int MAX_SRC_HEIGHT = 256;
	localparam int MAX_DST_SIZE   = 4096;

	localparam int COL_W  = $clog2(MAX_SRC_WIDTH);
	localparam int ROW_W  = $clog2(MAX_SRC_HEIGHT);
	localparam int BANK_AW = (COL_W - 1) + (ROW_W - 1);

	localparam int SW_W   = 9;
	localparam int DW_W   = 13;
	localparam int DXY_W  = 12;
	localparam int PIX_W  = 24;

	// Quotient carries 8 fraction bits; dx*sw stays below 2^20.
	localparam int NUM_W  = 28;
	localparam int REM_W  = 12;
	localparam int DIV_N  = NUM_W;

	// Spans the accept edge to the output register load, plus the out_valid strobe.
	localparam int LATENCY = DIV_N + 4;

	typedef enum logic [2:0] {
		REG_SRC_WIDTH  = 3'd0,
		REG_SRC_HEIGHT = 3'd1,
		REG_DST_WIDTH  = 3'd2,
		REG_DST_HEIGHT = 3'd3
	} cfg_reg_t;

	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_COMPUTE = 1'b1;

	typedef struct packed {
		logic             cmd;
		logic [COL_W-1:0] sx;
		logic [ROW_W-1:0] sy;
		logic [PIX_W-1:0] pix;
	} side_t;

	typedef struct packed {
		logic [8:0] d1;
		logic [7:0] d2;
		logic [8:0] d3;
		logic [8:0] d4;
	} weight_t;

endpackage

// ===== rtl/bilinear_rgb_scaler_top.sv =====
// Throughput: one transfer per cycle; busy stays low and loads travel the same pipeline.
// The depth is set by the scaling multiply, the 28-stage restoring divider, then a store read and two blend stages.
// The receiver cannot stall; each result strobes out_valid for exactly one cycle.
// Asynchronous active-low reset clears valid bits and sets all size registers to 256.
// The source store has no reset; an entry reads as undefined until loaded.
module bilinear_rgb_scaler_top
	import bls_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [DW_W-1:0]   cfg_data,
	input  logic              start,
	output logic              busy,
	input  logic              command,
	input  logic [COL_W-1:0]  src_x,
	input  logic [ROW_W-1:0]  src_y,
	input  logic [PIX_W-1:0]  src_pixel,
	input  logic [DXY_W-1:0]  dst_x,
	input  logic [DXY_W-1:0]  dst_y,
	output logic              out_valid,
	output logic [7:0]        out_red,
	output logic [7:0]        out_green,
	output logic [7:0]        out_blue
);

	logic [SW_W-1:0] src_width_q, src_height_q;
	logic [DW_W-1:0] dst_width_q, dst_height_q;
	logic [SW_W-1:0] sw_c, sh_c;
	logic [DW_W-1:0] dw_c, dh_c;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= SW_W'(256);
			src_height_q <= SW_W'(256);
			dst_width_q  <= DW_W'(256);
			dst_height_q <= DW_W'(256);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SRC_WIDTH:  src_width_q  <= cfg_data[SW_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= cfg_data[SW_W-1:0];
				REG_DST_WIDTH:  dst_width_q  <= cfg_data;
				REG_DST_HEIGHT: dst_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A size of zero counts as one; sizes above the maximum are clipped.
	always_comb begin
		sw_c = (src_width_q == '0) ? SW_W'(1) :
			(src_width_q > SW_W'(MAX_SRC_WIDTH)) ? SW_W'(MAX_SRC_WIDTH) : src_width_q;
		sh_c = (src_height_q == '0) ? SW_W'(1) :
			(src_height_q > SW_W'(MAX_SRC_HEIGHT)) ? SW_W'(MAX_SRC_HEIGHT) : src_height_q;
		dw_c = (dst_width_q == '0) ? DW_W'(1) :
			(dst_width_q > DW_W'(MAX_DST_SIZE)) ? DW_W'(MAX_DST_SIZE) : dst_width_q;
		dh_c = (dst_height_q == '0) ? DW_W'(1) :
			(dst_height_q > DW_W'(MAX_DST_SIZE)) ? DW_W'(MAX_DST_SIZE) : dst_height_q;
	end

	// Stage 1: scale the output coordinate by the source size.
	logic        vld_s [0:DIV_N];
	side_t       sb_s  [0:DIV_N];
	logic [19:0] mx_s1, my_s1;
	logic [NUM_W-1:0] qx, qy;

	always_ff @(posedge clk) begin
		mx_s1 <= 20'(dst_x) * 20'(sw_c);
		my_s1 <= 20'(dst_y) * 20'(sh_c);
		sb_s[0] <= '{cmd: command, sx: src_x, sy: src_y, pix: src_pixel};
		for (int k = 1; k <= DIV_N; k++) begin
			sb_s[k] <= sb_s[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_N; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			vld_s[0] <= start && !busy;
			for (int k = 1; k <= DIV_N; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	bls_div u_div_x (
		.clk (clk),
		.num ({mx_s1, 8'd0}),
		.den (dw_c),
		.quo (qx)
	);

	bls_div u_div_y (
		.clk (clk),
		.num ({my_s1, 8'd0}),
		.den (dh_c),
		.quo (qy)
	);

	// Neighbor positions, clamped to the image with edge replication.
	logic [19:0]      ox, oy;
	logic [COL_W-1:0] x0, x1;
	logic [ROW_W-1:0] y0, y1;
	weight_t          w_c;
	side_t            sb_e;
	logic             vld_e;

	assign sb_e  = sb_s[DIV_N];
	assign vld_e = vld_s[DIV_N];

	always_comb begin
		ox = qx[NUM_W-1:8];
		oy = qy[NUM_W-1:8];
		x0 = (ox > 20'(sw_c - 1'b1)) ? COL_W'(sw_c - 1'b1) : ox[COL_W-1:0];
		y0 = (oy > 20'(sh_c - 1'b1)) ? ROW_W'(sh_c - 1'b1) : oy[ROW_W-1:0];
		x1 = ((SW_W'(x0) + 1'b1) < sw_c) ? COL_W'(x0 + 1'b1) : x0;
		y1 = ((SW_W'(y0) + 1'b1) < sh_c) ? ROW_W'(y0 + 1'b1) : y0;
		w_c.d2 = qx[7:0];
		w_c.d1 = 9'd256 - 9'(qx[7:0]);
		w_c.d4 = 9'(qy[7:0]) + 9'd1;
		w_c.d3 = 9'd256 - w_c.d4;
	end

	// The store is split into four banks by column and row parity, so the
	// four neighbors always come from distinct banks or repeat one entry.
	logic [PIX_W-1:0] rd [0:1][0:1];

	for (genvar by = 0; by < 2; by++) begin : g_row
		for (genvar bx = 0; bx < 2; bx++) begin : g_col
			logic [COL_W-1:0] col;
			logic [ROW_W-1:0] row;
			logic             we;
			assign col = (x0[0] == bx[0]) ? x0 : x1;
			assign row = (y0[0] == by[0]) ? y0 : y1;
			assign we  = vld_e && (sb_e.cmd == CMD_LOAD) &&
				(sb_e.sx[0] == bx[0]) && (sb_e.sy[0] == by[0]);
			bls_bank u_bank (
				.clk   (clk),
				.we    (we),
				.waddr ({sb_e.sy[ROW_W-1:1], sb_e.sx[COL_W-1:1]}),
				.wdata (sb_e.pix),
				.raddr ({row[ROW_W-1:1], col[COL_W-1:1]}),
				.rdata (rd[by][bx])
			);
		end
	end

	logic    vld_s30;
	weight_t w_s30;
	logic    x0b_s30, x1b_s30, y0b_s30, y1b_s30;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s30 <= 1'b0;
		end else begin
			vld_s30 <= vld_e && (sb_e.cmd == CMD_COMPUTE);
		end
	end

	always_ff @(posedge clk) begin
		w_s30   <= w_c;
		x0b_s30 <= x0[0];
		x1b_s30 <= x1[0];
		y0b_s30 <= y0[0];
		y1b_s30 <= y1[0];
	end

	bls_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld       (vld_s30),
		.p1        (rd[y0b_s30][x0b_s30]),
		.p2        (rd[y0b_s30][x1b_s30]),
		.p3        (rd[y1b_s30][x0b_s30]),
		.p4        (rd[y1b_s30][x1b_s30]),
		.w         (w_s30),
		.out_valid (out_valid),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue)
	);

`ifndef SYNTHESIS
	a_result_from_compute: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $past(start && !busy && command == CMD_COMPUTE, LATENCY))
		else $error("result without a matching compute transfer");

	a_compute_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		$past(start && !busy && command == CMD_COMPUTE, LATENCY) && $past(arst_n, LATENCY)
		|-> out_valid)
		else $error("compute transfer produced no result");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		$past(start && !busy && command == CMD_LOAD, LATENCY) |-> !out_valid)
		else $error("load transfer produced a result");
`endif

endmodule

// ===== rtl/bls_div.sv =====
module bls_div
	import bls_pkg::*;
(
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [DW_W-1:0]  den,
	output logic [NUM_W-1:0] quo
);

	logic [REM_W-1:0] rem_s [0:DIV_N];
	logic [NUM_W-1:0] nq_s  [0:DIV_N];

	assign rem_s[0] = '0;
	assign nq_s[0]  = num;

	// Restoring division, one quotient bit per stage. The numerator shifts out
	// at the top of nq while quotient bits shift in at the bottom.
	for (genvar k = 1; k <= DIV_N; k++) begin : g_stage
		logic [REM_W:0] t;
		logic           ge;
		assign t  = {rem_s[k-1], nq_s[k-1][NUM_W-1]};
		assign ge = t >= den;
		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? REM_W'(t - den) : t[REM_W-1:0];
			nq_s[k]  <= {nq_s[k-1][NUM_W-2:0], ge};
		end
	end

	assign quo = nq_s[DIV_N];

endmodule

// ===== rtl/bls_bank.sv =====
module bls_bank
	import bls_pkg::*;
(
	input  logic               clk,
	input  logic               we,
	input  logic [BANK_AW-1:0] waddr,
	input  logic [PIX_W-1:0]   wdata,
	input  logic [BANK_AW-1:0] raddr,
	output logic [PIX_W-1:0]   rdata
);

	logic [PIX_W-1:0] mem [0:(1 << BANK_AW) - 1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/bls_blend.sv =====
module bls_blend
	import bls_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vld,
	input  logic [PIX_W-1:0] p1,
	input  logic [PIX_W-1:0] p2,
	input  logic [PIX_W-1:0] p3,
	input  logic [PIX_W-1:0] p4,
	input  weight_t          w,
	output logic             out_valid,
	output logic [7:0]       out_red,
	output logic [7:0]       out_green,
	output logic [7:0]       out_blue
);

	logic        vld_s1;
	logic [16:0] top_s1 [0:2];
	logic [16:0] bot_s1 [0:2];
	logic [8:0]  d3_s1;
	logic [8:0]  d4_s1;
	logic [7:0]  ch_s2  [0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			vld_s1    <= vld;
			out_valid <= vld_s1;
		end
	end

	// Channel 0 is red at bits 23:16, channel 2 is blue at bits 7:0.
	for (genvar c = 0; c < 3; c++) begin : g_ch
		localparam int SH = 16 - 8 * c;
		logic [25:0] sum;
		assign sum = 26'(top_s1[c]) * 26'(d3_s1) + 26'(bot_s1[c]) * 26'(d4_s1);
		always_ff @(posedge clk) begin
			top_s1[c] <= 17'(p1[SH +: 8]) * 17'(w.d1) + 17'(p2[SH +: 8]) * 17'(w.d2);
			bot_s1[c] <= 17'(p3[SH +: 8]) * 17'(w.d1) + 17'(p4[SH +: 8]) * 17'(w.d2);
			ch_s2[c]  <= sum[23:16];
		end
	end

	always_ff @(posedge clk) begin
		d3_s1 <= w.d3;
		d4_s1 <= w.d4;
	end

	assign out_red   = ch_s2[0];
	assign out_green = ch_s2[1];
	assign out_blue  = ch_s2[2];

endmodule

// ===== tb/tb_bilinear_rgb_scaler_top.sv =====
module tb_bilinear_rgb_scaler_top;
	import bls_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] UNUSED_INDEX = 3'd6;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	class pixel_scoreboard;
		logic [PIX_W-1:0] image [MAX_SRC_WIDTH*MAX_SRC_HEIGHT];
		bit               loaded [MAX_SRC_WIDTH*MAX_SRC_HEIGHT];
		int unsigned      src_w = 256, src_h = 256, dst_w = 256, dst_h = 256;
		rgb_t             expected_pixels [$];
		int               errors = 0;
		int               loads = 0;
		int               pixels_checked = 0;

		function int unsigned clip(int unsigned v, int unsigned top);
			if (v == 0) return 1;
			return (v > top) ? top : v;
		endfunction

		function void set_reg(logic [2:0] idx, logic [DW_W-1:0] val);
			case (idx)
				REG_SRC_WIDTH:  src_w = val[8:0];
				REG_SRC_HEIGHT: src_h = val[8:0];
				REG_DST_WIDTH:  dst_w = val;
				REG_DST_HEIGHT: dst_h = val;
				default: ;
			endcase
		endfunction

		// Source position of an output pixel: the 2x2 neighbourhood and its fractions.
		function void locate(logic [DXY_W-1:0] dx, logic [DXY_W-1:0] dy,
				output int unsigned x0, output int unsigned y0,
				output int unsigned x1, output int unsigned y1,
				output int unsigned fx, output int unsigned fy);
			int unsigned sw, sh;
			longint unsigned sxx, syy;
			sw = clip(src_w, MAX_SRC_WIDTH);
			sh = clip(src_h, MAX_SRC_HEIGHT);
			sxx = longint'(dx) * 256 * sw / clip(dst_w, MAX_DST_SIZE);
			syy = longint'(dy) * 256 * sh / clip(dst_h, MAX_DST_SIZE);
			fx = sxx[7:0];
			fy = syy[7:0];
			x0 = ((sxx >> 8) > sw - 1) ? sw - 1 : int'(sxx >> 8);
			y0 = ((syy >> 8) > sh - 1) ? sh - 1 : int'(syy >> 8);
			x1 = (x0 + 1 < sw) ? x0 + 1 : x0;
			y1 = (y0 + 1 < sh) ? y0 + 1 : y0;
		endfunction

		function logic [7:0] blend(logic [7:0] c1, logic [7:0] c2, logic [7:0] c3,
				logic [7:0] c4, int unsigned w1, int unsigned w2,
				int unsigned w3, int unsigned w4);
			longint unsigned sum;
			sum = (longint'(c1) * w1 + longint'(c2) * w2) * w3
				+ (longint'(c3) * w1 + longint'(c4) * w2) * w4;
			return sum[23:16];
		endfunction

		function void note_transfer(logic cmd, logic [7:0] sx, logic [7:0] sy,
				logic [PIX_W-1:0] pix, logic [DXY_W-1:0] dx, logic [DXY_W-1:0] dy);
			int unsigned x0, y0, x1, y1, fx, fy, v;
			logic [PIX_W-1:0] p1, p2, p3, p4;
			rgb_t px;
			if (cmd == CMD_LOAD) begin
				image[{sy, sx}] = pix;
				loaded[{sy, sx}] = 1;
				loads++;
				return;
			end
			locate(dx, dy, x0, y0, x1, y1, fx, fy);
			p1 = image[y0*256 + x0];
			p2 = image[y0*256 + x1];
			p3 = image[y1*256 + x0];
			p4 = image[y1*256 + x1];
			// The vertical weight is one above the fraction, so it spans 1 to 256.
			v = fy + 1;
			px.red   = blend(p1[23:16], p2[23:16], p3[23:16], p4[23:16], 256-fx, fx, 256-v, v);
			px.green = blend(p1[15:8], p2[15:8], p3[15:8], p4[15:8], 256-fx, fx, 256-v, v);
			px.blue  = blend(p1[7:0], p2[7:0], p3[7:0], p4[7:0], 256-fx, fx, 256-v, v);
			expected_pixels.push_back(px);
		endfunction

		function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			rgb_t px;
			if (expected_pixels.size() == 0) begin
				$error("unexpected output pixel %h %h %h", r, g, b);
				errors++;
				return;
			end
			px = expected_pixels.pop_front();
			pixels_checked++;
			if (r !== px.red) begin
				$error("out_red expected %h actual %h", px.red, r);
				errors++;
			end
			if (g !== px.green) begin
				$error("out_green expected %h actual %h", px.green, g);
				errors++;
			end
			if (b !== px.blue) begin
				$error("out_blue expected %h actual %h", px.blue, b);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 0;
	logic              arst_n = 0;
	logic              cfg_we = 0;
	logic [2:0]        cfg_index = '0;
	logic [DW_W-1:0]   cfg_data = '0;
	logic              start = 0;
	logic              busy;
	logic              command = CMD_LOAD;
	logic [COL_W-1:0]  src_x = '0;
	logic [ROW_W-1:0]  src_y = '0;
	logic [PIX_W-1:0]  src_pixel = '0;
	logic [DXY_W-1:0]  dst_x = '0;
	logic [DXY_W-1:0]  dst_y = '0;
	logic              out_valid;
	logic [7:0]        out_red, out_green, out_blue;

	pixel_scoreboard sb = new();
	bit idling = 1;
	int computes = 0;

	always #5 clk = ~clk;

	bilinear_rgb_scaler_top u_top (.*);

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1)
			sb.check_pixel(out_red, out_green, out_blue);
	end

	task automatic send(logic cmd, logic [7:0] sx, logic [7:0] sy, logic [PIX_W-1:0] pix,
			logic [DXY_W-1:0] dx, logic [DXY_W-1:0] dy);
		if (idling && $urandom_range(0, 4) == 0) begin
			@(negedge clk);
			start <= 0;
			repeat ($urandom_range(0, 17)) @(negedge clk);
		end
		@(negedge clk);
		start <= 1;
		command <= cmd;
		src_x <= sx;
		src_y <= sy;
		src_pixel <= pix;
		dst_x <= dx;
		dst_y <= dy;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_transfer(cmd, sx, sy, pix, dx, dy);
	endtask

	task automatic load_pixel(int unsigned x, int unsigned y, logic [PIX_W-1:0] pix);
		send(CMD_LOAD, x[7:0], y[7:0], pix, DXY_W'($urandom), DXY_W'($urandom));
	endtask

	// Any neighbour not yet loaded gets a random pixel first, so no read hits an empty entry.
	task automatic compute_pixel(logic [DXY_W-1:0] dx, logic [DXY_W-1:0] dy);
		int unsigned x0, y0, x1, y1, fx, fy;
		sb.locate(dx, dy, x0, y0, x1, y1, fx, fy);
		if (!sb.loaded[y0*256 + x0]) load_pixel(x0, y0, PIX_W'($urandom));
		if (!sb.loaded[y0*256 + x1]) load_pixel(x1, y0, PIX_W'($urandom));
		if (!sb.loaded[y1*256 + x0]) load_pixel(x0, y1, PIX_W'($urandom));
		if (!sb.loaded[y1*256 + x1]) load_pixel(x1, y1, PIX_W'($urandom));
		send(CMD_COMPUTE, 8'($urandom), 8'($urandom), PIX_W'($urandom), dx, dy);
		computes++;
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 0;
		wait (sb.expected_pixels.size() == 0);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [DW_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, val);
	endtask

	task automatic configure(int sw, int sh, int dw, int dh);
		drain();
		write_reg(REG_SRC_WIDTH, DW_W'(sw));
		write_reg(REG_SRC_HEIGHT, DW_W'(sh));
		write_reg(REG_DST_WIDTH, DW_W'(dw));
		write_reg(REG_DST_HEIGHT, DW_W'(dh));
	endtask

	task automatic random_phase(int n);
		int unsigned dw, dh;
		dw = sb.clip(sb.dst_w, MAX_DST_SIZE);
		dh = sb.clip(sb.dst_h, MAX_DST_SIZE);
		repeat (n) begin
			case ($urandom_range(0, 9))
				0, 1: load_pixel($urandom_range(0, 255), $urandom_range(0, 255),
					PIX_W'($urandom));
				2: compute_pixel(DXY_W'($urandom), DXY_W'($urandom));
				default: compute_pixel(DXY_W'($urandom_range(0, dw - 1)),
					DXY_W'($urandom_range(0, dh - 1)));
			endcase
		end
	endtask

	initial begin
		#5ms;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1;

		// Directed: a 2x2 image with extreme pixels, corners, and positions past the edge.
		configure(2, 2, 4, 4);
		load_pixel(0, 0, 24'h000000);
		load_pixel(1, 0, 24'hffffff);
		load_pixel(0, 1, 24'hff00ff);
		load_pixel(1, 1, 24'h00ff00);
		load_pixel(255, 255, 24'h123456);
		load_pixel(170, 85, 24'hedcba9);
		compute_pixel(0, 0);
		compute_pixel(1, 1);
		compute_pixel(3, 0);
		compute_pixel(0, 3);
		compute_pixel(3, 3);
		compute_pixel(2, 1);
		compute_pixel(4095, 4095);
		compute_pixel(4095, 0);
		compute_pixel(12'haaa, 12'h555);
		compute_pixel(12'h555, 12'haaa);

		drain();
		write_reg(UNUSED_INDEX, 13'h1fff);
		random_phase(15);
		configure(256, 256, 256, 256);
		random_phase(20);
		configure(1, 1, 1, 1);
		random_phase(10);
		configure(0, 0, 0, 0);
		random_phase(10);
		configure(511, 511, 8191, 8191);
		random_phase(20);
		configure(256, 256, 4096, 4096);
		random_phase(15);
		configure(5, 3, 4096, 7);
		random_phase(20);
		configure(256, 256, 1, 1);
		random_phase(10);
		configure(17, 9, 40, 30);
		random_phase(20);
		idling = 0;
		configure(9, 13, 23, 31);
		random_phase(20);

		drain();
		if (sb.expected_pixels.size() != 0) begin
			$error("%0d output pixels never arrived", sb.expected_pixels.size());
			sb.errors++;
		end
		$display("Covered %0d source loads and %0d output pixels (%0d checked)",
			sb.loads, computes, sb.pixels_checked);
		$display("over ten size settings, including zero, oversize and extreme registers.");
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
